/* rtl/nfc_card_whitelist_matcher_unit_assert.svh */
// assertion macros for the card whitelist matcher
`ifndef NFC_CARD_WHITELIST_MATCHER_UNIT_ASSERT_SVH
`define NFC_CARD_WHITELIST_MATCHER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define NCWM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define NCWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ncwm_pkg.sv */
// shared constants and helpers for the card whitelist matcher
package ncwm_pkg;

  // default number of table entries
  localparam int TABLE_DEPTH_DEF = 32;

  // fixed field widths
  localparam int OUT_IDX_W = 6;
  localparam int ID_W      = 64;

  // frame layout
  localparam logic [4:0] LEN_POS      = 5'd12;
  localparam logic [4:0] POS_MAX      = 5'd31;
  localparam logic [4:0] HDR_LEN      = 5'd4;
  localparam logic [4:0] HDR_FAIL_MIN = 5'd3;
  localparam logic [7:0] MAX_ID_BYTES = 8'd8;

  // operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_ARM  = 1'b1;

  // result outcome codes
  typedef enum logic [2:0] {
    OUT_FAIL    = 3'd0,
    OUT_BADLEN  = 3'd1,
    OUT_UNKNOWN = 3'd2,
    OUT_RECOG   = 3'd3,
    OUT_ADDED   = 3'd4,
    OUT_DUP     = 3'd5,
    OUT_FULL    = 3'd6
  } outcome_t;

  // header bytes of a failed-detection notification
  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = 8'h60;
      2'd1: b = 8'h07;
      2'd2: b = 8'h01;
      2'd3: b = 8'ha1;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* rtl/nfc_card_whitelist_matcher_unit.sv */
// top level of the card whitelist matcher: frame parser, table search and enrolment
//
//  channel | handshake              | ports
//  --------+------------------------+-----------------------------------------------
//  input   | start && !busy         | in_operation, in_frame_byte, in_frame_end
//  result  | out_valid (one cycle)  | out_outcome, out_card_id, out_match_index,
//          |                        | out_card_count
//
// an arm request or a frame byte that is not the last is taken at once; busy stays low.
// a rejected frame (failed detection, bad length) reports in the cycle after its last byte.
// a frame with a valid id walks the table through the memory read port, one entry per
// cycle, and stops early on a hit; an empty table skips the walk. the result appears in
// the same cycle that busy drops.
// synchronous active-low reset clears the counters and flags; the table needs no clear.
// results are never held off: out_valid is a single-cycle strobe.
module nfc_card_whitelist_matcher_unit
  import ncwm_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_operation,
  input  logic [7:0]           in_frame_byte,
  input  logic                 in_frame_end,
  output logic                 out_valid,
  output logic [2:0]           out_outcome,
  output logic [ID_W-1:0]      out_card_id,
  output logic [OUT_IDX_W-1:0] out_match_index,
  output logic [OUT_IDX_W-1:0] out_card_count
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int EXT_W = CNT_W + OUT_IDX_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

  state_t             state_r, state_nxt;
  logic [4:0]         pos_r, pos_nxt;
  logic               hdr_r, hdr_nxt;
  logic [7:0]         len_r, len_nxt;
  logic [ID_W-1:0]    acc_r, acc_nxt;
  logic               arm_r, arm_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [ID_W-1:0]    key_r, key_nxt;
  logic [IDX_W-1:0]   addr_r, addr_nxt;
  logic               issue_r, issue_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               found_r, found_nxt;
  logic [CNT_W-1:0]   hit_r, hit_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_outcome_r, out_outcome_nxt;
  logic [ID_W-1:0]    out_card_id_r, out_card_id_nxt;
  logic [OUT_IDX_W-1:0] out_match_r, out_match_nxt;
  logic [OUT_IDX_W-1:0] out_count_r, out_count_nxt;

  // card table
  logic [ID_W-1:0]    mem_r [TABLE_DEPTH];
  logic [ID_W-1:0]    rd_data_r;
  logic               rd_en;
  logic               wr_en;

  // frame byte decode
  logic               accept;
  logic [8:0]         pos_w;
  logic [7:0]         len_sel;
  logic               len_ok;
  logic [8:0]         id_end;
  logic               take;
  logic [ID_W-1:0]    acc_upd;
  logic               hdr_upd;
  logic               frame_fail;
  logic               frame_bad;
  logic               key_hit;
  logic [CNT_W-1:0]   addr_ext;
  logic [CNT_W-1:0]   cmp_ext;
  logic [CNT_W-1:0]   match_sel;
  logic [CNT_W-1:0]   cnt_sel;
  logic [EXT_W-1:0]   match_ext;
  logic [EXT_W-1:0]   cnt_ext;

  // assertion helpers
  logic               append_go;
  logic               added_out;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // header, length and id byte tracking
  always_comb begin
    pos_w   = {4'b0000, pos_r};
    len_sel = (pos_r == LEN_POS) ? in_frame_byte : len_r;
    len_ok  = (pos_r >= LEN_POS) && (len_sel != 8'd0) && (len_sel <= MAX_ID_BYTES);
    id_end  = {4'b0000, LEN_POS} + {1'b0, len_sel};
    take    = len_ok && (pos_r > LEN_POS) && (pos_w <= id_end);
    acc_upd = take ? {acc_r[ID_W-9:0], in_frame_byte} : acc_r;
    hdr_upd = hdr_r && !((pos_r < HDR_LEN) && (in_frame_byte != hdr_byte(pos_r[1:0])));
    frame_fail = (pos_r >= HDR_FAIL_MIN) && hdr_upd;
    frame_bad  = !len_ok || (pos_w < id_end);
  end

  assign key_hit  = (rd_data_r == key_r);
  assign addr_ext = CNT_W'(addr_r);
  assign cmp_ext  = CNT_W'(cmp_idx_r);

  // next-state logic
  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    hdr_nxt         = hdr_r;
    len_nxt         = len_r;
    acc_nxt         = acc_r;
    arm_nxt         = arm_r;
    count_nxt       = count_r;
    key_nxt         = key_r;
    addr_nxt        = addr_r;
    issue_nxt       = issue_r;
    cmp_vld_nxt     = cmp_vld_r;
    cmp_idx_nxt     = cmp_idx_r;
    found_nxt       = found_r;
    hit_nxt         = hit_r;
    out_valid_nxt   = 1'b0;
    out_outcome_nxt = out_outcome_r;
    out_card_id_nxt = out_card_id_r;
    match_sel       = '0;
    cnt_sel         = count_r;
    rd_en           = 1'b0;
    wr_en           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OP_ARM) begin
            arm_nxt = 1'b1;
          end else if (!in_frame_end) begin
            hdr_nxt = hdr_upd;
            len_nxt = len_sel;
            acc_nxt = acc_upd;
            pos_nxt = (pos_r < POS_MAX) ? pos_r + 5'd1 : pos_r;
          end else begin
            // frame end: frame state returns to reset
            pos_nxt = '0;
            hdr_nxt = 1'b1;
            len_nxt = '0;
            acc_nxt = '0;
            if (frame_fail) begin
              out_valid_nxt   = 1'b1;
              out_outcome_nxt = OUT_FAIL;
              out_card_id_nxt = '0;
            end else if (frame_bad) begin
              out_valid_nxt   = 1'b1;
              out_outcome_nxt = OUT_BADLEN;
              out_card_id_nxt = '0;
            end else begin
              key_nxt     = acc_upd;
              found_nxt   = 1'b0;
              hit_nxt     = '0;
              addr_nxt    = '0;
              cmp_vld_nxt = 1'b0;
              if (count_r == '0) begin
                issue_nxt = 1'b0;
                state_nxt = S_FIN;
              end else begin
                issue_nxt = 1'b1;
                state_nxt = S_SCAN;
              end
            end
          end
        end
      end

      S_SCAN: begin
        // read one entry a cycle, compare the previous read
        rd_en       = issue_r;
        cmp_vld_nxt = issue_r;
        cmp_idx_nxt = addr_r;
        if (issue_r) begin
          addr_nxt  = addr_r + 1'b1;
          issue_nxt = (addr_ext + 1'b1) < count_r;
        end
        if (cmp_vld_r && key_hit) begin
          found_nxt   = 1'b1;
          hit_nxt     = cmp_ext + 1'b1;
          issue_nxt   = 1'b0;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_FIN;
        end else if (cmp_vld_r && !issue_r) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        // decide, append on enrolment, report
        state_nxt       = S_IDLE;
        out_valid_nxt   = 1'b1;
        out_card_id_nxt = key_r;
        if (arm_r) begin
          arm_nxt = 1'b0;
          if (found_r) begin
            out_outcome_nxt = OUT_DUP;
            match_sel       = hit_r;
          end else if (count_r >= DEPTH_C) begin
            out_outcome_nxt = OUT_FULL;
          end else begin
            wr_en           = 1'b1;
            count_nxt       = count_r + 1'b1;
            cnt_sel         = count_r + 1'b1;
            match_sel       = count_r + 1'b1;
            out_outcome_nxt = OUT_ADDED;
          end
        end else if (found_r) begin
          out_outcome_nxt = OUT_RECOG;
          match_sel       = hit_r;
        end else begin
          out_outcome_nxt = OUT_UNKNOWN;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    match_ext     = EXT_W'(match_sel);
    cnt_ext       = EXT_W'(cnt_sel);
    out_match_nxt = match_ext[OUT_IDX_W-1:0];
    out_count_nxt = cnt_ext[OUT_IDX_W-1:0];
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      hdr_r       <= 1'b1;
      len_r       <= '0;
      acc_r       <= '0;
      arm_r       <= 1'b0;
      count_r     <= '0;
      issue_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pos_r         <= pos_nxt;
      hdr_r         <= hdr_nxt;
      len_r         <= len_nxt;
      acc_r         <= acc_nxt;
      arm_r         <= arm_nxt;
      count_r       <= count_nxt;
      issue_r       <= issue_nxt;
      cmp_vld_r     <= cmp_vld_nxt;
      out_valid_r   <= out_valid_nxt;
      key_r         <= key_nxt;
      addr_r        <= addr_nxt;
      cmp_idx_r     <= cmp_idx_nxt;
      found_r       <= found_nxt;
      hit_r         <= hit_nxt;
      out_outcome_r <= out_outcome_nxt;
      out_card_id_r <= out_card_id_nxt;
      out_match_r   <= out_match_nxt;
      out_count_r   <= out_count_nxt;
    end
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[count_r[IDX_W-1:0]] <= key_r;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[addr_r];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_outcome     = out_outcome_r;
  assign out_card_id     = out_card_id_r;
  assign out_match_index = out_match_r;
  assign out_card_count  = out_count_r;

  assign append_go = (state_r == S_FIN) && arm_r && !found_r && (count_r < DEPTH_C);
  assign added_out = out_valid_r && (out_outcome_r == OUT_ADDED);

  `include "nfc_card_whitelist_matcher_unit_assert.svh"

  // an arm transaction leaves enrolment armed
  `NCWM_ASSERT_NEXT(a_arm_set, accept && (in_operation == OP_ARM), arm_r, "arm not set")

  // an append grows the table by exactly one
  `NCWM_ASSERT_NEXT(a_append_count, append_go, count_r == $past(count_r) + 1'b1, "count not grown")

  // an added card is reported at the last table slot
  `NCWM_ASSERT_SAME(a_added_index, added_out, out_match_r == out_count_r, "added index mismatch")

  // a table walk only runs over a non-empty table
  `NCWM_ASSERT_SAME(a_scan_nonempty, state_r == S_SCAN, count_r != '0, "scan of empty table")

endmodule
